// File: src/tlsfe_pkg.sv
// ----------------------------------------------------------------------------
// TLS feature extractor package
// Shared types, constants and codes for the TLS packet feature extractor.
// ----------------------------------------------------------------------------
package tlsfe_pkg;

   // Feature sequence length and the counter width that holds it
   localparam int unsigned SEQ_LEN   = 10;
   localparam int unsigned CNT_W     = 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_TARGET  = 2'd1;
   localparam logic [1:0] CSR_CLIENT  = 2'd2;

   // TLS content types
   localparam logic [7:0] CT_CCS       = 8'h14;
   localparam logic [7:0] CT_ALERT     = 8'h15;
   localparam logic [7:0] CT_HANDSHAKE = 8'h16;
   localparam logic [7:0] CT_APPDATA   = 8'h17;
   localparam logic [7:0] CT_HEARTBEAT = 8'h18;

   // Handshake message types
   localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
   localparam logic [7:0] HS_SERVER_HELLO = 8'h02;
   localparam logic [7:0] HS_CERTIFICATE  = 8'h0b;
   localparam logic [7:0] HS_HELLO_DONE   = 8'h0e;
   localparam logic [7:0] HS_TYPE_10      = 8'h10;
   localparam logic [7:0] HS_TYPE_14      = 8'h14;

   // Record version range
   localparam logic [15:0] VER_LOW  = 16'h0300;
   localparam logic [15:0] VER_HIGH = 16'h0304;

   // Record class codes
   localparam logic [3:0] REC_NONE         = 4'd0;
   localparam logic [3:0] REC_HS_OTHER     = 4'd1;
   localparam logic [3:0] REC_APPDATA      = 4'd2;
   localparam logic [3:0] REC_CCS          = 4'd3;
   localparam logic [3:0] REC_ALERT        = 4'd4;
   localparam logic [3:0] REC_CLIENT_HELLO = 4'd5;
   localparam logic [3:0] REC_SERVER_HELLO = 4'd6;
   localparam logic [3:0] REC_CERTIFICATE  = 4'd7;
   localparam logic [3:0] REC_HELLO_DONE   = 4'd8;
   localparam logic [3:0] REC_TYPE_10      = 4'd9;
   localparam logic [3:0] REC_TYPE_14      = 4'd10;
   localparam logic [3:0] REC_HEARTBEAT    = 4'd11;

   localparam logic [2:0] VER_UNKNOWN = 3'd0;

   // Minimum payload lengths for each decoded field
   localparam logic [15:0] LEN_VERSION = 16'd3;
   localparam logic [15:0] LEN_RECORD  = 16'd5;
   localparam logic [15:0] LEN_HS_TYPE = 16'd10;

   // One captured packet summary
   typedef struct packed {
      logic        new_flow;
      logic        is_tcp;
      logic [15:0] source_port;
      logic [31:0] tcp_seq;
      logic [31:0] tcp_ack;
      logic [7:0]  tcp_flag_bits;
      logic [31:0] now_ms;
      logic [15:0] payload_length;
      logic [7:0]  first_byte;
      logic [15:0] version_word;
      logic [15:0] length_word;
      logic [7:0]  hs_byte;
   } req_type;

   // Decoded payload fields
   typedef struct packed {
      logic [3:0]  record_code;
      logic [15:0] record_length;
      logic [2:0]  version_code;
      logic [7:0]  flag_code;
   } decode_type;

endpackage

// File: src/tls_packet_feature_extractor.sv
// ----------------------------------------------------------------------------
// TLS packet feature extractor
// Tracks one TLS flow and emits a feature transaction for each collected
// packet: direction, timing, wrapped seq/ack deltas, flags, record class.
// ----------------------------------------------------------------------------
// A request waits in the input register until the result register can take its result.
// Throughput: one request per cycle while results are taken; the input and result
// registers decouple the two channels and the flow state is updated in the same single pass.
// Reset: synchronous, clears the flow state and both channels, and returns
// the configuration to enable 0, target 10, client port 0.
module tls_packet_feature_extractor
   import tlsfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_new_flow,
   input  logic        req_is_tcp,
   input  logic [15:0] req_source_port,
   input  logic [31:0] req_tcp_seq,
   input  logic [31:0] req_tcp_ack,
   input  logic [7:0]  req_tcp_flag_bits,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_first_byte,
   input  logic [15:0] req_version_word,
   input  logic [15:0] req_length_word,
   input  logic [7:0]  req_hs_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_direction,
   output logic [31:0] rsp_rel_time,
   output logic [31:0] rsp_gap_time,
   output logic [31:0] rsp_seq_delta,
   output logic [31:0] rsp_ack_delta,
   output logic [7:0]  rsp_flag_code,
   output logic [3:0]  rsp_record_code,
   output logic [15:0] rsp_record_length,
   output logic [2:0]  rsp_version_code,
   output logic [3:0]  rsp_slot_index,
   output logic        rsp_flow_ready
);

   // Configuration
   logic             enable_ff;
   logic [CNT_W-1:0] target_ff;
   logic [15:0]      client_port_ff;

   // Input register
   logic             pkt_valid_ff, pkt_valid_in;
   req_type          pkt_ff;
   decode_type       dec;

   // Flow state
   logic             hs_seen_ff, hs_seen_in;
   logic [31:0]      first_time_ff, first_time_in;
   logic [31:0]      last_time_ff, last_time_in;
   logic [31:0]      prev_seq_ff [2];
   logic [31:0]      prev_seq_in [2];
   logic [31:0]      prev_ack_ff [2];
   logic [31:0]      prev_ack_in [2];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             emit;
   logic             dir_in;
   logic [31:0]      rel_in, gap_in, seqd_in, ackd_in;
   logic [CNT_W-1:0] slot_in;
   logic             ready_in;
   logic             dir_ff;
   logic [31:0]      rel_ff, gap_ff, seqd_ff, ackd_ff;
   logic [7:0]       flag_ff;
   logic [3:0]       rec_ff;
   logic [15:0]      rlen_ff;
   logic [2:0]       ver_ff;
   logic [CNT_W-1:0] slot_ff;
   logic             fready_ff;

   logic             advance;
   logic [CNT_W-1:0] target_eff;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   // Process the held transaction when the result register can take it
   assign advance   = pkt_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~pkt_valid_ff | advance;

   assign pkt_valid_in = (req_valid & req_ready) | (pkt_valid_ff & ~advance);

   // Clamp the target to the sequence length; a zero target also selects the sequence length
   assign target_eff = (target_ff == '0 || target_ff > CNT_W'(SEQ_LEN)) ?
                       CNT_W'(SEQ_LEN) : target_ff;

   tlsfe_decode u_decode (
      .pkt (pkt_ff),
      .dec (dec)
   );

   // Flow state update and feature computation
   always_comb begin
      hs_seen_in    = hs_seen_ff;
      first_time_in = first_time_ff;
      last_time_in  = last_time_ff;
      prev_seq_in   = prev_seq_ff;
      prev_ack_in   = prev_ack_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      emit          = 1'b0;
      dir_in        = 1'b0;
      rel_in        = '0;
      gap_in        = '0;
      seqd_in       = '0;
      ackd_in       = '0;
      slot_in       = count_ff;
      ready_in      = 1'b0;
      if (advance) begin
         // Clear the flow first
         if (pkt_ff.new_flow) begin
            hs_seen_in     = 1'b0;
            first_time_in  = '0;
            last_time_in   = '0;
            prev_seq_in[0] = '0;
            prev_seq_in[1] = '0;
            prev_ack_in[0] = '0;
            prev_ack_in[1] = '0;
            count_in       = '0;
            done_in        = 1'b0;
         end
         if (enable_ff && !done_in) begin
            // Latch the first ClientHello time
            if (!hs_seen_in && dec.record_code == REC_CLIENT_HELLO) begin
               hs_seen_in    = 1'b1;
               first_time_in = pkt_ff.now_ms;
            end
            slot_in = count_in;
            if ((hs_seen_in || pkt_ff.is_tcp) && count_in < CNT_W'(SEQ_LEN)) begin
               emit = 1'b1;
               if (pkt_ff.is_tcp) begin
                  dir_in              = (pkt_ff.source_port != client_port_ff);
                  seqd_in             = pkt_ff.tcp_seq - prev_seq_in[dir_in];
                  prev_seq_in[dir_in] = pkt_ff.tcp_seq;
                  ackd_in             = pkt_ff.tcp_ack - prev_ack_in[~dir_in];
                  prev_ack_in[~dir_in] = pkt_ff.tcp_ack;
               end
               rel_in       = pkt_ff.now_ms - first_time_in;
               gap_in       = pkt_ff.now_ms - last_time_in;
               count_in     = count_in + CNT_W'(1);
               last_time_in = pkt_ff.now_ms;
               ready_in     = (count_in == target_eff);
            end
            if (count_in >= target_eff)
               done_in = 1'b1;
         end
      end
   end

   // Hold the result until taken, load a new one on emit
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (advance && emit)
         rsp_valid_in = 1'b1;
   end

   // Control, configuration and flow state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         target_ff      <= CNT_W'(SEQ_LEN);
         client_port_ff <= '0;
         pkt_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hs_seen_ff     <= 1'b0;
         first_time_ff  <= '0;
         last_time_ff   <= '0;
         prev_seq_ff[0] <= '0;
         prev_seq_ff[1] <= '0;
         prev_ack_ff[0] <= '0;
         prev_ack_ff[1] <= '0;
         count_ff       <= '0;
         done_ff        <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE: enable_ff      <= csr_data[0];
               CSR_TARGET: target_ff      <= csr_data[CNT_W-1:0];
               CSR_CLIENT: client_port_ff <= csr_data;
               default: ;
            endcase
         end
         pkt_valid_ff  <= pkt_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hs_seen_ff    <= hs_seen_in;
         first_time_ff <= first_time_in;
         last_time_ff  <= last_time_in;
         prev_seq_ff   <= prev_seq_in;
         prev_ack_ff   <= prev_ack_in;
         count_ff      <= count_in;
         done_ff       <= done_in;
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pkt_ff.new_flow       <= req_new_flow;
         pkt_ff.is_tcp         <= req_is_tcp;
         pkt_ff.source_port    <= req_source_port;
         pkt_ff.tcp_seq        <= req_tcp_seq;
         pkt_ff.tcp_ack        <= req_tcp_ack;
         pkt_ff.tcp_flag_bits  <= req_tcp_flag_bits;
         pkt_ff.now_ms         <= req_now_ms;
         pkt_ff.payload_length <= req_payload_length;
         pkt_ff.first_byte     <= req_first_byte;
         pkt_ff.version_word   <= req_version_word;
         pkt_ff.length_word    <= req_length_word;
         pkt_ff.hs_byte        <= req_hs_byte;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         dir_ff    <= dir_in;
         rel_ff    <= rel_in;
         gap_ff    <= gap_in;
         seqd_ff   <= seqd_in;
         ackd_ff   <= ackd_in;
         flag_ff   <= dec.flag_code;
         rec_ff    <= dec.record_code;
         rlen_ff   <= dec.record_length;
         ver_ff    <= dec.version_code;
         slot_ff   <= slot_in;
         fready_ff <= ready_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_direction     = dir_ff;
   assign rsp_rel_time      = rel_ff;
   assign rsp_gap_time      = gap_ff;
   assign rsp_seq_delta     = seqd_ff;
   assign rsp_ack_delta     = ackd_ff;
   assign rsp_flag_code     = flag_ff;
   assign rsp_record_code   = rec_ff;
   assign rsp_record_length = rlen_ff;
   assign rsp_version_code  = ver_ff;
   assign rsp_slot_index    = slot_ff;
   assign rsp_flow_ready    = fready_ff;

endmodule

// File: src/tlsfe_decode.sv
// ----------------------------------------------------------------------------
// TLS record decoder
// Classifies the TLS record and version of one packet and reorders its
// TCP flag bits. Purely combinational.
// ----------------------------------------------------------------------------
module tlsfe_decode
   import tlsfe_pkg::*;
(
   input  req_type    pkt,
   output decode_type dec
);

   logic [3:0]  hs_code;
   logic [3:0]  rec_code;
   logic [15:0] rec_length;
   logic [2:0]  ver_code;
   logic [7:0]  flags;

   // Map the handshake message type
   always_comb begin
      case (pkt.hs_byte)
         HS_CLIENT_HELLO: hs_code = REC_CLIENT_HELLO;
         HS_SERVER_HELLO: hs_code = REC_SERVER_HELLO;
         HS_CERTIFICATE:  hs_code = REC_CERTIFICATE;
         HS_HELLO_DONE:   hs_code = REC_HELLO_DONE;
         HS_TYPE_10:      hs_code = REC_TYPE_10;
         HS_TYPE_14:      hs_code = REC_TYPE_14;
         default:         hs_code = REC_HS_OTHER;
      endcase
   end

   // Classify the record by content type
   always_comb begin
      rec_code = REC_NONE;
      if (pkt.payload_length >= LEN_RECORD) begin
         case (pkt.first_byte)
            CT_CCS:       rec_code = REC_CCS;
            CT_ALERT:     rec_code = REC_ALERT;
            CT_HANDSHAKE: rec_code =
                             (pkt.payload_length < LEN_HS_TYPE) ? REC_HS_OTHER : hs_code;
            CT_APPDATA:   rec_code = REC_APPDATA;
            CT_HEARTBEAT: rec_code = REC_HEARTBEAT;
            default:      rec_code = REC_NONE;
         endcase
      end
   end

   // Record length only when the record header is complete
   assign rec_length = (pkt.payload_length >= LEN_RECORD) ? pkt.length_word : 16'd0;

   // Version code: SSLv3 is one, TLS 1.0 to 1.3 follow
   always_comb begin
      ver_code = VER_UNKNOWN;
      if (pkt.payload_length >= LEN_VERSION && pkt.version_word inside {[VER_LOW:VER_HIGH]})
         ver_code = pkt.version_word[2:0] + 3'd1;
   end

   // Reverse the flag byte so that cwr lands in bit 0; zero when not TCP
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         flags[7-i] = pkt.is_tcp & pkt.tcp_flag_bits[i];
      end
   end

   assign dec = {rec_code, rec_length, ver_code, flags};

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS packet feature extractor testbench
// Drives packet summaries through the extractor with random sender gaps and
// receiver stalls, predicts every feature transaction from a local model of
// the flow state, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module testbench;
   import tlsfe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned PRINT_LIMIT = 200;

   // Receiver stall patterns
   localparam int unsigned RX_OPEN   = 0;
   localparam int unsigned RX_COIN   = 1;
   localparam int unsigned RX_SPARSE = 2;
   localparam int unsigned RX_TOGGLE = 3;

   // One expected feature transaction
   typedef struct packed {
      logic        direction;
      logic [31:0] rel_time;
      logic [31:0] gap_time;
      logic [31:0] seq_delta;
      logic [31:0] ack_delta;
      logic [7:0]  flag_code;
      logic [3:0]  record_code;
      logic [15:0] record_length;
      logic [2:0]  version_code;
      logic [3:0]  slot_index;
      logic        flow_ready;
   } feature_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_new_flow = 1'b0;
   logic        req_is_tcp = 1'b0;
   logic [15:0] req_source_port = '0;
   logic [31:0] req_tcp_seq = '0;
   logic [31:0] req_tcp_ack = '0;
   logic [7:0]  req_tcp_flag_bits = '0;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_payload_length = '0;
   logic [7:0]  req_first_byte = '0;
   logic [15:0] req_version_word = '0;
   logic [15:0] req_length_word = '0;
   logic [7:0]  req_hs_byte = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_direction;
   logic [31:0] rsp_rel_time;
   logic [31:0] rsp_gap_time;
   logic [31:0] rsp_seq_delta;
   logic [31:0] rsp_ack_delta;
   logic [7:0]  rsp_flag_code;
   logic [3:0]  rsp_record_code;
   logic [15:0] rsp_record_length;
   logic [2:0]  rsp_version_code;
   logic [3:0]  rsp_slot_index;
   logic        rsp_flow_ready;

   // Configuration as the block should hold it
   logic        cfg_enable = 1'b0;
   logic [3:0]  cfg_target = 4'd10;
   logic [15:0] cfg_client_port = '0;

   // Flow state as the block should hold it
   logic        hs_seen;
   logic [31:0] first_ms;
   logic [31:0] last_ms;
   logic [31:0] prev_seq [2];
   logic [31:0] prev_ack [2];
   logic [3:0]  collected;
   logic        flow_done;

   feature_type expected_features [$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   // Stimulus pacing
   logic [31:0] wall_ms = '0;
   int unsigned burst_left = 0;
   bit          sender_steady = 1'b0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned stall_mode = RX_OPEN;
   int unsigned mode_left = 0;

   tls_packet_feature_extractor i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_new_flow       (req_new_flow),
      .req_is_tcp         (req_is_tcp),
      .req_source_port    (req_source_port),
      .req_tcp_seq        (req_tcp_seq),
      .req_tcp_ack        (req_tcp_ack),
      .req_tcp_flag_bits  (req_tcp_flag_bits),
      .req_now_ms         (req_now_ms),
      .req_payload_length (req_payload_length),
      .req_first_byte     (req_first_byte),
      .req_version_word   (req_version_word),
      .req_length_word    (req_length_word),
      .req_hs_byte        (req_hs_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_direction      (rsp_direction),
      .rsp_rel_time       (rsp_rel_time),
      .rsp_gap_time       (rsp_gap_time),
      .rsp_seq_delta      (rsp_seq_delta),
      .rsp_ack_delta      (rsp_ack_delta),
      .rsp_flag_code      (rsp_flag_code),
      .rsp_record_code    (rsp_record_code),
      .rsp_record_length  (rsp_record_length),
      .rsp_version_code   (rsp_version_code),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_flow_ready     (rsp_flow_ready)
   );

   always #10 clock = ~clock;

   // Abort a run that goes past the cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Flow model
   // ------------------------------------------------------------------

   function automatic void forget_flow();
      hs_seen = 1'b0;
      first_ms = '0;
      last_ms = '0;
      prev_seq[0] = '0;
      prev_seq[1] = '0;
      prev_ack[0] = '0;
      prev_ack[1] = '0;
      collected = '0;
      flow_done = 1'b0;
   endfunction

   function automatic logic [3:0] record_class(input req_type p);
      logic [3:0] cls;
      cls = REC_NONE;
      if (p.payload_length >= LEN_RECORD) begin
         case (p.first_byte)
            CT_CCS:       cls = REC_CCS;
            CT_ALERT:     cls = REC_ALERT;
            CT_APPDATA:   cls = REC_APPDATA;
            CT_HEARTBEAT: cls = REC_HEARTBEAT;
            CT_HANDSHAKE: begin
               cls = REC_HS_OTHER;
               if (p.payload_length >= LEN_HS_TYPE) begin
                  case (p.hs_byte)
                     HS_CLIENT_HELLO: cls = REC_CLIENT_HELLO;
                     HS_SERVER_HELLO: cls = REC_SERVER_HELLO;
                     HS_CERTIFICATE:  cls = REC_CERTIFICATE;
                     HS_HELLO_DONE:   cls = REC_HELLO_DONE;
                     HS_TYPE_10:      cls = REC_TYPE_10;
                     HS_TYPE_14:      cls = REC_TYPE_14;
                     default:         cls = REC_HS_OTHER;
                  endcase
               end
            end
            default: cls = REC_NONE;
         endcase
      end
      return cls;
   endfunction

   function automatic logic [2:0] version_class(input req_type p);
      logic [15:0] step;
      step = p.version_word - VER_LOW + 16'd1;
      if (p.payload_length >= LEN_VERSION && p.version_word >= VER_LOW
          && p.version_word <= VER_HIGH)
         return step[2:0];
      return VER_UNKNOWN;
   endfunction

   // Advance the flow model by one accepted packet and queue its features
   function automatic void track_flow(input req_type p);
      feature_type f;
      logic [3:0]  goal;
      logic [3:0]  cls;
      logic        back;
      if (p.new_flow)
         forget_flow();
      if (!cfg_enable || flow_done)
         return;
      goal = (cfg_target == 4'd0 || cfg_target > SEQ_LEN) ? 4'(SEQ_LEN) : cfg_target;
      cls = record_class(p);
      if (!hs_seen && cls == REC_CLIENT_HELLO) begin
         hs_seen = 1'b1;
         first_ms = p.now_ms;
      end
      if ((hs_seen || p.is_tcp) && collected < SEQ_LEN) begin
         f = '0;
         f.slot_index = collected;
         if (p.is_tcp) begin
            f.direction = (p.source_port != cfg_client_port);
            back = ~f.direction;
            for (int i = 0; i < 8; i++)
               f.flag_code[7 - i] = p.tcp_flag_bits[i];
            f.seq_delta = p.tcp_seq - prev_seq[f.direction];
            prev_seq[f.direction] = p.tcp_seq;
            f.ack_delta = p.tcp_ack - prev_ack[back];
            prev_ack[back] = p.tcp_ack;
         end
         f.rel_time = p.now_ms - first_ms;
         f.gap_time = p.now_ms - last_ms;
         f.record_code = cls;
         f.record_length = (p.payload_length >= LEN_RECORD) ? p.length_word : 16'd0;
         f.version_code = version_class(p);
         collected = collected + 4'd1;
         last_ms = p.now_ms;
         f.flow_ready = (collected == goal);
         expected_features.push_back(f);
      end
      if (collected >= goal)
         flow_done = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Result comparison
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Match each accepted result against the oldest expectation
   always @(posedge clock) begin : result_compare
      feature_type got;
      feature_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_direction, rsp_rel_time, rsp_gap_time, rsp_seq_delta, rsp_ack_delta,
                rsp_flag_code, rsp_record_code, rsp_record_length, rsp_version_code,
                rsp_slot_index, rsp_flow_ready};
         if (expected_features.size() == 0) begin
            report_mismatch("feature transaction with none expected");
         end else begin
            want = expected_features.pop_front();
            compare_field("direction", 32'(got.direction), 32'(want.direction));
            compare_field("rel_time", got.rel_time, want.rel_time);
            compare_field("gap_time", got.gap_time, want.gap_time);
            compare_field("seq_delta", got.seq_delta, want.seq_delta);
            compare_field("ack_delta", got.ack_delta, want.ack_delta);
            compare_field("flag_code", 32'(got.flag_code), 32'(want.flag_code));
            compare_field("record_code", 32'(got.record_code), 32'(want.record_code));
            compare_field("record_length", 32'(got.record_length),
                          32'(want.record_length));
            compare_field("version_code", 32'(got.version_code), 32'(want.version_code));
            compare_field("slot_index", 32'(got.slot_index), 32'(want.slot_index));
            compare_field("flow_ready", 32'(got.flow_ready), 32'(want.flow_ready));
         end
      end
   end

   // Receiver: switch stall pattern now and then, and honour long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(RX_OPEN, RX_TOGGLE);
            mode_left = $urandom_range(16, 120);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
               default:   rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one packet, pausing between bursts unless the sender is steady, and model it once accepted
   task automatic send_packet(input req_type p);
      int unsigned pause;
      if (!sender_steady && burst_left == 0) begin
         pause = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      if (burst_left != 0)
         burst_left--;
      req_valid          <= 1'b1;
      req_new_flow       <= p.new_flow;
      req_is_tcp         <= p.is_tcp;
      req_source_port    <= p.source_port;
      req_tcp_seq        <= p.tcp_seq;
      req_tcp_ack        <= p.tcp_ack;
      req_tcp_flag_bits  <= p.tcp_flag_bits;
      req_now_ms         <= p.now_ms;
      req_payload_length <= p.payload_length;
      req_first_byte     <= p.first_byte;
      req_version_word   <= p.version_word;
      req_length_word    <= p.length_word;
      req_hs_byte        <= p.hs_byte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_flow(p);
   endtask

   // Drop valid and wait until every expected transaction has come out
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_features.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] data);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_ENABLE: cfg_enable = data[0];
         CSR_TARGET: cfg_target = data[3:0];
         CSR_CLIENT: cfg_client_port = data;
         default: ;
      endcase
   endtask

   // Build a packet with the decode fields given and random TCP fields
   function automatic req_type tls_packet(input logic nf, input logic tcp,
                                          input logic [15:0] port, input logic [15:0] plen,
                                          input logic [7:0] b0, input logic [7:0] b9,
                                          input logic [15:0] ver);
      req_type p;
      wall_ms = wall_ms + $urandom_range(0, 40);
      p.new_flow = nf;
      p.is_tcp = tcp;
      p.source_port = port;
      p.tcp_seq = $urandom();
      p.tcp_ack = $urandom();
      p.tcp_flag_bits = 8'($urandom_range(0, 255));
      p.now_ms = wall_ms;
      p.payload_length = plen;
      p.first_byte = b0;
      p.version_word = ver;
      p.length_word = 16'($urandom());
      p.hs_byte = b9;
      return p;
   endfunction

   // Random packet shaped like real traffic: flows usually open with a
   // ClientHello and carry mostly TLS records over TCP
   function automatic req_type random_packet(input bit start);
      req_type     p;
      int unsigned pick;
      p.new_flow = start || ($urandom_range(0, 15) == 0);
      p.is_tcp = ($urandom_range(0, 7) != 0);
      pick = $urandom_range(0, 9);
      p.source_port = (pick < 5) ? cfg_client_port : (pick < 9) ? 16'd443 : 16'($urandom());
      p.tcp_seq = $urandom();
      p.tcp_ack = $urandom();
      p.tcp_flag_bits = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 49) == 0)
         wall_ms = $urandom();
      else
         wall_ms = wall_ms + $urandom_range(0, 2000);
      p.now_ms = wall_ms;
      case ($urandom_range(0, 9))
         0: p.first_byte = 8'($urandom());
         1: p.first_byte = CT_CCS;
         2: p.first_byte = CT_ALERT;
         3: p.first_byte = CT_APPDATA;
         4: p.first_byte = CT_HEARTBEAT;
         default: p.first_byte = CT_HANDSHAKE;
      endcase
      case ($urandom_range(0, 7))
         0: p.hs_byte = HS_CLIENT_HELLO;
         1: p.hs_byte = HS_SERVER_HELLO;
         2: p.hs_byte = HS_CERTIFICATE;
         3: p.hs_byte = HS_HELLO_DONE;
         4: p.hs_byte = HS_TYPE_10;
         5: p.hs_byte = HS_TYPE_14;
         default: p.hs_byte = 8'($urandom());
      endcase
      case ($urandom_range(0, 5))
         0: p.payload_length = 16'($urandom_range(0, 11));
         1: p.payload_length = 16'($urandom());
         default: p.payload_length = 16'($urandom_range(10, 1500));
      endcase
      if (start && $urandom_range(0, 4) != 0) begin
         p.first_byte = CT_HANDSHAKE;
         p.hs_byte = HS_CLIENT_HELLO;
         p.payload_length = 16'($urandom_range(10, 600));
      end
      p.version_word = ($urandom_range(0, 9) < 7) ? VER_LOW + 16'($urandom_range(0, 5))
                                                  : 16'($urandom());
      p.length_word = 16'($urandom());
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset the block is disabled: nothing may come out
   task automatic test_disabled_after_reset();
      send_packet(tls_packet(1'b1, 1'b1, 16'd0, 16'd100, CT_HANDSHAKE, HS_CLIENT_HELLO,
                             16'h0303));
      send_packet(tls_packet(1'b0, 1'b1, 16'd443, 16'd50, CT_APPDATA, 8'h00, 16'h0303));
      write_register(CSR_ENABLE, 16'd1);
   endtask

   // Every record class, version boundary and TCP field extreme
   task automatic test_record_decode();
      req_type batch [$];
      req_type p;
      wall_ms = 32'hFFFF_FFC0;
      // not TCP and no ClientHello yet: dropped
      batch.push_back(tls_packet(1'b1, 1'b0, 16'h1234, 16'd0, 8'h00, 8'h00, 16'h0000));
      // ClientHello over non-TCP opens the handshake and is collected
      batch.push_back(tls_packet(1'b0, 1'b0, 16'h1234, 16'd100, CT_HANDSHAKE,
                                 HS_CLIENT_HELLO, 16'h0301));
      p = tls_packet(1'b0, 1'b1, 16'h0000, 16'd5, CT_CCS, 8'h00, VER_LOW);
      p.tcp_seq = '1;
      p.tcp_ack = '0;
      p.tcp_flag_bits = 8'h01;
      batch.push_back(p);
      p = tls_packet(1'b0, 1'b1, 16'hFFFF, 16'd6, CT_ALERT, 8'h00, VER_HIGH);
      p.tcp_seq = '0;
      p.tcp_ack = '1;
      p.tcp_flag_bits = 8'h80;
      batch.push_back(p);
      // handshake record too short to hold a message type
      batch.push_back(tls_packet(1'b0, 1'b1, 16'h0000, 16'd9, CT_HANDSHAKE,
                                 HS_CLIENT_HELLO, 16'h0305));
      batch.push_back(tls_packet(1'b0, 1'b1, 16'hFFFF, 16'd10, CT_HANDSHAKE,
                                 HS_SERVER_HELLO, 16'h02FF));
      p = tls_packet(1'b0, 1'b1, 16'hFFFF, 16'd10, CT_HANDSHAKE, HS_CERTIFICATE, 16'h0302);
      p.tcp_flag_bits = 8'hFF;
      batch.push_back(p);
      p = tls_packet(1'b0, 1'b1, 16'hFFFF, 16'd10, CT_HANDSHAKE, HS_HELLO_DONE, 16'h0303);
      p.tcp_flag_bits = 8'h00;
      batch.push_back(p);
      batch.push_back(tls_packet(1'b1, 1'b1, 16'h0000, 16'd10, CT_HANDSHAKE,
                                 HS_CLIENT_HELLO, 16'h0303));
      batch.push_back(tls_packet(1'b0, 1'b1, 16'hFFFF, 16'd200, CT_HANDSHAKE,
                                 HS_TYPE_10, 16'h0303));
      batch.push_back(tls_packet(1'b0, 1'b1, 16'h0000, 16'd200, CT_HANDSHAKE,
                                 HS_TYPE_14, 16'h0303));
      batch.push_back(tls_packet(1'b0, 1'b1, 16'h0000, 16'd200, CT_HANDSHAKE,
                                 8'h03, 16'h0303));
      batch.push_back(tls_packet(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, CT_APPDATA,
                                 8'h00, 16'h0304));
      batch.push_back(tls_packet(1'b0, 1'b1, 16'h0000, 16'd5, CT_HEARTBEAT,
                                 8'h00, 16'h0300));
      // too short for a record, long enough for a version
      batch.push_back(tls_packet(1'b0, 1'b1, 16'h0000, 16'd4, 8'hFF, 8'h00, 16'h0303));
      batch.push_back(tls_packet(1'b0, 1'b1, 16'h0000, 16'd2, CT_APPDATA, 8'h00,
                                 16'h0303));
      // not TCP but the handshake is open: collected with zero TCP fields
      batch.push_back(tls_packet(1'b0, 1'b0, 16'h0000, 16'd300, 8'h00, 8'h00, 16'hFFFF));
      foreach (batch[i])
         send_packet(batch[i]);
   endtask

   // Small targets, a done flow, and a target lowered below the count
   task automatic test_target_handling();
      write_register(CSR_TARGET, 16'd1);
      send_packet(tls_packet(1'b1, 1'b1, 16'd0, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      send_packet(tls_packet(1'b0, 1'b1, 16'd0, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      send_packet(tls_packet(1'b1, 1'b0, 16'd7, 16'd40, CT_HANDSHAKE, HS_CLIENT_HELLO,
                             16'h0301));
      write_register(CSR_TARGET, 16'd10);
      send_packet(tls_packet(1'b1, 1'b1, 16'd0, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      send_packet(tls_packet(1'b0, 1'b1, 16'd443, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      send_packet(tls_packet(1'b0, 1'b1, 16'd0, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      write_register(CSR_TARGET, 16'd2);
      send_packet(tls_packet(1'b0, 1'b1, 16'd443, 16'd10, CT_ALERT, 8'h00, 16'h0303));
      send_packet(tls_packet(1'b0, 1'b1, 16'd0, 16'd10, CT_ALERT, 8'h00, 16'h0303));
   endtask

   // While disabled packets are ignored but a new flow still clears
   task automatic test_enable_gating();
      write_register(CSR_TARGET, 16'd10);
      send_packet(tls_packet(1'b1, 1'b1, 16'd0, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      write_register(CSR_ENABLE, 16'd0);
      send_packet(tls_packet(1'b1, 1'b1, 16'd0, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      send_packet(tls_packet(1'b0, 1'b1, 16'd443, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
      write_register(CSR_ENABLE, 16'd1);
      send_packet(tls_packet(1'b0, 1'b1, 16'd443, 16'd10, CT_APPDATA, 8'h00, 16'h0303));
   endtask

   // Random flows over several register settings
   task automatic test_random_flows();
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_TARGET, 16'd10);
               write_register(CSR_CLIENT, 16'd0);
            end
            1: write_register(CSR_TARGET, 16'd1);
            2: write_register(CSR_TARGET, 16'd0);
            9: begin
               write_register(CSR_TARGET, 16'd15);
               write_register(CSR_CLIENT, 16'hFFFF);
            end
            default: begin
               write_register(CSR_TARGET, 16'($urandom()));
               write_register(CSR_CLIENT, 16'($urandom()));
            end
         endcase
         if (phase == 4) begin
            write_register(CSR_ENABLE, {15'($urandom()), 1'b0});
            for (int n = 0; n < 20; n++)
               send_packet(random_packet(n == 0));
            write_register(CSR_ENABLE, {15'($urandom()), 1'b1});
         end
         for (int n = 0; n < 115; n++)
            send_packet(random_packet(n == 0));
      end
   endtask

   // Hold the receiver off while the sender keeps offering, so the block
   // fills and pushes back on its input
   task automatic test_output_backpressure();
      req_type p;
      write_register(CSR_TARGET, 16'd10);
      hold_request = 400;
      sender_steady = 1'b1;
      for (int n = 0; n < 40; n++) begin
         p = random_packet(n % 10 == 0);
         p.is_tcp = 1'b1;
         send_packet(p);
      end
      sender_steady = 1'b0;
      settle_block();
   endtask

   initial begin
      forget_flow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_disabled_after_reset();
      test_record_decode();
      test_target_handling();
      test_enable_gating();
      test_output_backpressure();
      test_random_flows();
      settle_block();
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// File: files.f
src/tlsfe_pkg.sv
src/tlsfe_decode.sv
src/tls_packet_feature_extractor.sv
bench/testbench.sv
